// ===== rtl/core/irdig_pkg.sv =====
// ----------------------------------------------------------------------------
// irdig_pkg
// Shared constants and helpers for the integer to radix digit converter.
// ----------------------------------------------------------------------------
package irdig_pkg;

	localparam int VALUE_W      = 64;
	localparam int RADIX_W      = 6;
	localparam int CHAR_W       = 7;
	localparam int MAX_DIGITS   = 64;
	localparam int DIGIT_W      = 6;
	localparam int DIG_IDX_W    = $clog2(MAX_DIGITS);
	localparam int BITS_PER_CYC = 8;
	localparam int STEPS        = VALUE_W / BITS_PER_CYC;
	localparam int STEP_W       = $clog2(STEPS);

	localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(48);
	localparam logic [CHAR_W-1:0] CHAR_ALPHA = CHAR_W'(55);
	localparam logic [CHAR_W-1:0] CHAR_MINUS = CHAR_W'(45);
	localparam logic [CHAR_W-1:0] CHAR_NINE  = CHAR_W'(57);
	localparam logic [CHAR_W-1:0] CHAR_A     = CHAR_W'(65);
	localparam logic [CHAR_W-1:0] CHAR_Z     = CHAR_W'(90);

	// digit value 0..35 to ascii '0'..'9', 'A'..'Z'
	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] dx;
		dx = CHAR_W'(d);
		if (d > DIGIT_W'(9)) begin
			return dx + CHAR_ALPHA;
		end
		return dx + CHAR_ZERO;
	endfunction

	function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
		if (r < RADIX_MIN) begin
			return RADIX_MIN;
		end
		if (r > RADIX_MAX) begin
			return RADIX_MAX;
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/integer_to_radix_digits_top.sv =====
// ----------------------------------------------------------------------------
// integer_to_radix_digits_top
// Converts a signed 64-bit value into ASCII digits of radix 2..36, sign first,
// most significant digit first, by repeated division in a shared divider.
// ----------------------------------------------------------------------------
//
// channel   ports                       transfer
// input     start, busy, value, radix   edge with start high and busy low
// result    strobe, character, last     every edge with strobe high
//
// each digit is a full division of the quotient in the shared divider, which retires 8
// quotient bits per cycle; busy stays high until the last character is registered,
// so no new item is taken while one is being converted. digits go to a 64-entry
// buffer, read back reversed.
// arst_n clears the sequencer and the strobe; the buffer is not cleared.
// results cannot be stalled, the strobe shows each character for one cycle.

module integer_to_radix_digits_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [irdig_pkg::VALUE_W-1:0] value,
	input  logic        [irdig_pkg::RADIX_W-1:0] radix,
	output logic                                strobe,
	output logic        [irdig_pkg::CHAR_W-1:0]  character,
	output logic                                last
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_PREP,
		ST_OUT
	} state_t;

	state_t                            state_q;
	logic [irdig_pkg::VALUE_W-1:0]     quo_q;
	logic [irdig_pkg::DIGIT_W-1:0]     rem_q;
	logic [irdig_pkg::RADIX_W-1:0]     radix_q;
	logic                              neg_q;
	logic                              cut_q;
	logic [irdig_pkg::STEP_W-1:0]      step_q;
	logic [irdig_pkg::DIG_IDX_W-1:0]   nd_q;
	logic [irdig_pkg::DIG_IDX_W-1:0]   rd_q;
	logic [irdig_pkg::DIGIT_W-1:0]     dout_q;
	logic                              strobe_q;
	logic [irdig_pkg::CHAR_W-1:0]      char_q;
	logic                              last_q;

	logic [irdig_pkg::DIGIT_W-1:0]     mem [irdig_pkg::MAX_DIGITS];

	logic [irdig_pkg::VALUE_W-1:0]     quo_d;
	logic [irdig_pkg::DIGIT_W-1:0]     rem_d;
	logic [irdig_pkg::DIG_IDX_W-1:0]   rd_addr;
	logic [irdig_pkg::VALUE_W-1:0]     mag;
	logic                              digit_done;
	logic                              last_digit;
	logic                              out_last;

	assign mag = value[irdig_pkg::VALUE_W-1] ? (~value + irdig_pkg::VALUE_W'(1)) : value;

	// restoring division, 8 quotient bits per cycle; remainder stays below radix
	always_comb begin
		logic [irdig_pkg::DIGIT_W:0] trial;
		quo_d = quo_q;
		rem_d = rem_q;
		for (int i = 0; i < irdig_pkg::BITS_PER_CYC; i++) begin
			trial = {rem_d, quo_d[irdig_pkg::VALUE_W-1]};
			quo_d = {quo_d[irdig_pkg::VALUE_W-2:0], 1'b0};
			if (trial >= {1'b0, radix_q}) begin
				rem_d    = irdig_pkg::DIGIT_W'(trial - {1'b0, radix_q});
				quo_d[0] = 1'b1;
			end else begin
				rem_d = trial[irdig_pkg::DIGIT_W-1:0];
			end
		end
	end

	assign digit_done = (state_q == ST_DIV) && (step_q == irdig_pkg::STEP_W'(irdig_pkg::STEPS - 1));
	assign last_digit = (quo_d == '0) || (nd_q == irdig_pkg::DIG_IDX_W'(irdig_pkg::MAX_DIGITS - 1));
	// a sign plus 64 digits is cut to 64 characters, dropping the final digit
	assign out_last   = (rd_q == '0) || (cut_q && (rd_q == irdig_pkg::DIG_IDX_W'(1)));
	assign rd_addr    = (state_q == ST_OUT) ? (rd_q - irdig_pkg::DIG_IDX_W'(1)) : rd_q;

	always_ff @(posedge clk) begin
		if (digit_done) begin
			mem[nd_q] <= rem_d;
		end
		dout_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			strobe_q <= 1'b0;
			step_q   <= '0;
			nd_q     <= '0;
			rd_q     <= '0;
			cut_q    <= 1'b0;
			neg_q    <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						quo_q   <= mag;
						rem_q   <= '0;
						radix_q <= irdig_pkg::clamp_radix(radix);
						neg_q   <= value[irdig_pkg::VALUE_W-1];
						step_q  <= '0;
						nd_q    <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					step_q <= step_q + irdig_pkg::STEP_W'(1);
					if (digit_done) begin
						if (last_digit) begin
							rd_q  <= nd_q;
							cut_q <= neg_q &&
								(nd_q == irdig_pkg::DIG_IDX_W'(irdig_pkg::MAX_DIGITS - 1));
							state_q <= ST_PREP;
						end else begin
							nd_q  <= nd_q + irdig_pkg::DIG_IDX_W'(1);
							quo_q <= quo_d;
							rem_q <= '0;
						end
					end else begin
						quo_q <= quo_d;
						rem_q <= rem_d;
					end
				end
				ST_PREP: begin
					// buffer read of the top digit is in flight; sign goes out now
					if (neg_q) begin
						strobe_q <= 1'b1;
						char_q   <= irdig_pkg::CHAR_MINUS;
						last_q   <= 1'b0;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					strobe_q <= 1'b1;
					char_q   <= irdig_pkg::digit_char(dout_q);
					last_q   <= out_last;
					rd_q     <= rd_addr;
					if (out_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign strobe    = strobe_q;
	assign character = char_q;
	assign last      = last_q;

endmodule

// ===== rtl/core/irdig_checker.sv =====
// ----------------------------------------------------------------------------
// irdig_checker
// Port-level checks of the radix digit converter, bound to the top level.
// ----------------------------------------------------------------------------
module irdig_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                start,
	input logic                                busy,
	input logic                                strobe,
	input logic [irdig_pkg::CHAR_W-1:0]        character,
	input logic                                last
);

	// a transfer in starts the conversion and nothing comes out in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !strobe)
		else $error("accepted item did not start a conversion");

	// only the final character may show up after the block went idle
	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> busy)
		else $error("non-final character while idle");

	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |=> !strobe)
		else $error("character right after the final one");

	a_char_set: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (character == irdig_pkg::CHAR_MINUS) ||
			((character >= irdig_pkg::CHAR_ZERO) && (character <= irdig_pkg::CHAR_NINE)) ||
			((character >= irdig_pkg::CHAR_A) && (character <= irdig_pkg::CHAR_Z)))
		else $error("character outside the digit set");

	// the sign can never be the final character
	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (character == irdig_pkg::CHAR_MINUS) |-> !last)
		else $error("sign marked as final character");

endmodule

bind integer_to_radix_digits_top irdig_checker u_irdig_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.strobe    (strobe),
	.character (character),
	.last      (last)
);
